[hdl/assert_macros.svh]
// assertion helpers for fnv_hashed_key_table
// the including module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FHKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FHKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fhkt_pkg.sv]
package fhkt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int HASH_W  = 32;
    localparam int VALUE_W = 32;

    // operation codes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_GETH   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_ENTRIES = 2'd0;
    localparam logic [1:0] REG_SEED    = 2'd1;
    localparam logic [1:0] REG_PRIME   = 2'd2;

    // update request from the sequencer to the slot store
    typedef struct packed {
        logic               set;        // fill slot idx
        logic               drop;       // empty slot idx
        logic               clear_all;  // empty slots below n_active
        logic [IDX_W-1:0]   idx;
        logic [HASH_W-1:0]  hash;
        logic [VALUE_W-1:0] value;
        logic               present;
        logic [CNT_W-1:0]   n_active;
    } slot_cmd_t;

endpackage

[hdl/fnv_hashed_key_table.sv]
// fnv-1a hashed key table
// input stream: one key byte per beat on s_tdata, operation and has_value on
// s_tuser, s_tlast marks the final byte; the operation runs on that beat.
// output stream: one result beat for each input beat with s_tlast set.
// config channel: cfg_index selects entries_in_use (0), hash_seed (1) or
// fnv_prime (2); cfg_ready is always high, write only while idle.
// throughput: non-final key bytes are taken one per cycle (one 32x32 multiply
// per byte). a final beat starts a slot scan through the single compare unit,
// one slot per cycle from the slot memory read port, until a hit or the last
// slot in use. clear, unknown operations, a zero hash or zero slots in use
// skip the scan and go straight to the result.
// s_tready stays low from the final beat until the result is loaded into the
// output register.
// reset: all slots empty, registers back to their defaults, no key started.
// a stalled receiver holds the result in the output register; the next result
// waits in the sequencer until the register is free.
`include "assert_macros.svh"

module fnv_hashed_key_table (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key_byte[7:0], direct_hash[39:8], value_in[71:40]
    input  logic [3:0]  s_tuser,   // operation[2:0], has_value[3]
    input  logic        s_tlast,   // last_byte
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_hash[31:0], value_out[63:32]
    output logic        m_tuser,   // success
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fhkt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // configuration
    logic [6:0]         entries_reg;
    logic [HASH_W-1:0]  seed_reg;
    logic [HASH_W-1:0]  prime_reg;
    logic [CNT_W-1:0]   n_active;

    // sequencer state
    logic [1:0]         state_reg,   state_next;
    logic               started_reg, started_next;
    logic [CNT_W-1:0]   idx_reg,     idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;

    // item payload
    logic [HASH_W-1:0]  acc_reg,      acc_next;
    logic [HASH_W-1:0]  key_reg,      key_next;
    logic [2:0]         op_reg,       op_next;
    logic [VALUE_W-1:0] value_reg,    value_next;
    logic               has_val_reg,  has_val_next;
    logic [HASH_W-1:0]  res_hash_reg, res_hash_next;
    logic [VALUE_W-1:0] res_val_reg,  res_val_next;
    logic               res_ok_reg,   res_ok_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        m_tdata_reg,  m_tdata_next;
    logic               m_tuser_reg,  m_tuser_next;

    // hash datapath
    logic [7:0]         key_byte;
    logic [HASH_W-1:0]  hash_base;
    logic [HASH_W-1:0]  hash_mix;
    logic [HASH_W-1:0]  hash_prod;
    logic [HASH_W-1:0]  hash_now;

    // slot store
    slot_cmd_t          cmd;
    logic [HASH_W-1:0]  rd_hash;
    logic [VALUE_W-1:0] rd_value;
    logic               rd_occ;
    logic               rd_present;
    logic               hit;
    logic               last_slot;
    logic               accept;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // an entries_in_use above the table size counts as the table size
    assign n_active = (entries_reg > 7'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(entries_reg);

    // fnv-1a step: xor the byte in, multiply by the prime modulo 2^32
    assign key_byte  = s_tdata[7:0];
    assign hash_base = started_reg ? acc_reg : seed_reg;
    assign hash_mix  = hash_base ^ {24'd0, key_byte};
    assign hash_prod = hash_mix * prime_reg;
    // a zero byte leaves the hash alone
    assign hash_now  = (key_byte != 8'd0) ? hash_prod : hash_base;

    // compare unit: add looks for an empty slot, the others for the key
    always_comb
    begin
        case (op_reg)
            OP_ADD:  hit = !rd_occ;
            default: hit = rd_occ && (rd_hash == key_reg);
        endcase
    end

    assign last_slot = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == n_active);

    fhkt_slot_store u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_idx     (idx_reg[IDX_W-1:0]),
        .rd_hash    (rd_hash),
        .rd_value   (rd_value),
        .rd_occ     (rd_occ),
        .rd_present (rd_present)
    );

    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        acc_next      = acc_reg;
        key_next      = key_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        has_val_next  = has_val_reg;
        res_hash_next = res_hash_reg;
        res_val_next  = res_val_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        cmd           = '0;
        cmd.idx       = cmp_idx_reg;
        cmd.hash      = key_reg;
        cmd.value     = value_reg;
        cmd.present   = has_val_reg;
        cmd.n_active  = n_active;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tlast)
                    begin
                        if (key_byte != 8'd0)
                        begin
                            acc_next     = hash_now;
                            started_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // final beat: latch the operation and start the scan
                        started_next  = 1'b0;
                        op_next       = s_tuser[2:0];
                        key_next      = (s_tuser[2:0] == OP_GETH) ? s_tdata[39:8] : hash_now;
                        value_next    = s_tdata[71:40];
                        has_val_next  = s_tuser[3];
                        idx_next      = '0;
                        cmp_vld_next  = 1'b0;
                        res_hash_next = '0;
                        res_val_next  = '0;
                        res_ok_next   = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_DONE;
                end
                else if ((op_reg > OP_CLEAR) || (n_active == '0) || (key_reg == '0))
                begin
                    // nothing to do, result stays all zero
                    state_next = ST_DONE;
                end
                else
                begin
                    // issue the next slot read
                    cmp_vld_next = (idx_reg < n_active);
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                    if (idx_reg < n_active)
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    // compare the slot read last cycle
                    if (cmp_vld_reg)
                    begin
                        if (hit)
                        begin
                            state_next = ST_DONE;
                            case (op_reg) inside
                                OP_ADD:
                                begin
                                    cmd.set       = 1'b1;
                                    res_hash_next = key_reg;
                                    res_ok_next   = 1'b1;
                                end
                                OP_REMOVE:
                                begin
                                    cmd.drop    = 1'b1;
                                    res_ok_next = 1'b1;
                                end
                                OP_GET, OP_GETH:
                                begin
                                    if (rd_present)
                                    begin
                                        res_ok_next  = 1'b1;
                                        res_val_next = rd_value;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else if (last_slot)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_val_reg, res_hash_reg};
                    m_tuser_next  = res_ok_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            entries_reg  <= 7'd64;
            seed_reg     <= 32'd2166136261;
            prime_reg    <= 32'd16777619;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ENTRIES: entries_reg <= cfg_data[6:0];
                    REG_SEED:    seed_reg    <= cfg_data;
                    REG_PRIME:   prime_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        acc_reg      <= acc_next;
        key_reg      <= key_next;
        op_reg       <= op_next;
        value_reg    <= value_next;
        has_val_reg  <= has_val_next;
        res_hash_reg <= res_hash_next;
        res_val_reg  <= res_val_next;
        res_ok_reg   <= res_ok_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // a final beat always starts the scan
    `FHKT_ASSERT_NEXT(a_last_starts_scan, accept && s_tlast, state_reg == ST_SCAN, "final beat did not start scan")
    // a nonzero result hash only comes from a successful add
    `FHKT_ASSERT_NOW(a_hash_implies_ok, m_tvalid_reg && (m_tdata_reg[31:0] != '0), m_tuser_reg, "result hash without success")
    // a finished result is loaded and the sequencer returns to idle
    `FHKT_ASSERT_NEXT(a_done_loads_out, (state_reg == ST_DONE) && out_free, m_tvalid_reg && (state_reg == ST_IDLE), "result not loaded")

endmodule

[hdl/fhkt_slot_store.sv]
module fhkt_slot_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fhkt_pkg::slot_cmd_t        cmd,
    input  logic [fhkt_pkg::IDX_W-1:0] rd_idx,
    output logic [fhkt_pkg::HASH_W-1:0]  rd_hash,
    output logic [fhkt_pkg::VALUE_W-1:0] rd_value,
    output logic                       rd_occ,
    output logic                       rd_present
);
    import fhkt_pkg::*;

    logic [HASH_W-1:0]  slot_hash_mem  [ENTRIES];
    logic [VALUE_W-1:0] slot_value_mem [ENTRIES];
    logic [ENTRIES-1:0] occ_reg;
    logic [ENTRIES-1:0] present_reg;
    logic [HASH_W-1:0]  rd_hash_reg;
    logic [VALUE_W-1:0] rd_value_reg;
    logic               rd_occ_reg;
    logic               rd_present_reg;

    // occupancy and value-present flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            present_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CNT_W'(i) < cmd.n_active)
                begin
                    occ_reg[i]     <= 1'b0;
                    present_reg[i] <= 1'b0;
                end
            end
        end
        else if (cmd.set)
        begin
            occ_reg[cmd.idx]     <= 1'b1;
            present_reg[cmd.idx] <= cmd.present;
        end
        else if (cmd.drop)
        begin
            occ_reg[cmd.idx]     <= 1'b0;
            present_reg[cmd.idx] <= 1'b0;
        end
    end

    // slot memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            slot_hash_mem[cmd.idx]  <= cmd.hash;
            slot_value_mem[cmd.idx] <= cmd.value;
        end
        rd_hash_reg    <= slot_hash_mem[rd_idx];
        rd_value_reg   <= slot_value_mem[rd_idx];
        rd_occ_reg     <= occ_reg[rd_idx];
        rd_present_reg <= present_reg[rd_idx];
    end

    assign rd_hash    = rd_hash_reg;
    assign rd_value   = rd_value_reg;
    assign rd_occ     = rd_occ_reg;
    assign rd_present = rd_present_reg;

endmodule
